// ===== rtl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator package
// Sizes, codes, sequencer states and word helpers shared by the allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // Frame map geometry.
  localparam int PAGE_INDEX_BITS = 10;
  localparam int WORD_BITS       = 32;
  localparam int TOTAL_FRAMES    = 1 << PAGE_INDEX_BITS;
  localparam int OFF_BITS        = $clog2(WORD_BITS);
  localparam int WADDR_BITS      = PAGE_INDEX_BITS - OFF_BITS;
  localparam int MAP_WORDS       = TOTAL_FRAMES / WORD_BITS;

  // Field and counter widths.
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = PAGE_INDEX_BITS + 1;
  localparam int SEEN_BITS   = PAGE_INDEX_BITS + 2;
  localparam int CHUNK_BITS  = OFF_BITS + 1;

  typedef enum logic [OP_BITS-1:0] {
    OP_OCCUPY = 2'd0,
    OP_FREE   = 2'd1,
    OP_FIND   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BOUND = 2'd1,
    STATUS_TAKEN = 2'd2,
    STATUS_NOMEM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_RESP
  } state_t;

  // Number of zero bits below the lowest set bit; WORD_BITS when none is set.
  function automatic logic [CHUNK_BITS-1:0] ctz(logic [WORD_BITS-1:0] w);
    logic [CHUNK_BITS-1:0] r;
    r = CHUNK_BITS'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = CHUNK_BITS'(i);
      end
    end
    return r;
  endfunction

  // Mask with the k lowest bits set, k from 0 to WORD_BITS.
  function automatic logic [WORD_BITS-1:0] low_ones(logic [CHUNK_BITS-1:0] k);
    logic [WORD_BITS:0] t;
    t = ((WORD_BITS + 1)'(1) << k) - (WORD_BITS + 1)'(1);
    return t[WORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/bpfa_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one allocator operation per transaction.
interface bpfa_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpfa_pkg::OP_BITS-1:0]         operation;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] start_page;
  logic [bpfa_pkg::COUNT_BITS-1:0]      count;

  modport source (output valid, output operation, output start_page, output count,
                  input ready);
  modport sink   (input valid, input operation, input start_page, input count,
                  output ready);
endinterface

// Response channel: one result per request.
interface bpfa_resp_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpfa_pkg::STATUS_BITS-1:0]     status;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] page_no;
  logic                                 page_free;

  modport source (output valid, output status, output page_no, output page_free,
                  input ready);
  modport sink   (input valid, input status, input page_no, input page_free,
                  output ready);
endinterface

// Configuration channel: writes the search start register.
interface bpfa_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] search_start;

  modport source (output valid, output search_start, input ready);
  modport sink   (input valid, input search_start, output ready);
endinterface

// ===== rtl/bitmap_page_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator
// One bit per page frame in a word memory, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req  : operation (occupy run, free run, find free run, query frame),
//          start_page and count. Accepted only while the sequencer is idle.
//   resp : status, page_no and page_free, one result per request, held in an
//          output register until taken.
//   cfg  : writes search_start, the frame where a find begins; always ready.
// Sequencing, from the accepting edge to the result in the output register:
//   a request settled at once (zero or oversized count) goes straight to the
//   output stage; query reads and checks its map word; occupy and free read
//   and update in turn each map word the run touches, occupy stopping at the
//   first taken frame. Find reads map words and handles one free or occupied
//   stretch of equal bits per execute step, so its length is set by the
//   free/occupied pattern.
// A new request is accepted in the cycle after the result is loaded, even while
//   that result still waits. If the receiver stalls, the sequencer holds its next
//   result until the output register is taken.
// Reset clears the per-word valid bits, so the whole map reads as free at
//   once, and search_start returns to frame 0.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit (
  input  logic              clk,
  input  logic              rst,
  bpfa_cfg_if.sink          cfg,
  bpfa_req_if.sink          req,
  bpfa_resp_if.source       resp
);

  // Sequencer and request registers.
  bpfa_pkg::state_t                     state, state_next;
  bpfa_pkg::op_t                        op, op_next;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] cur, cur_next;
  logic [bpfa_pkg::COUNT_BITS-1:0]      cnt_left, cnt_left_next;
  logic [bpfa_pkg::COUNT_BITS-1:0]      n_req, n_req_next;
  logic [bpfa_pkg::COUNT_BITS-1:0]      run_len, run_len_next;
  logic [bpfa_pkg::SEEN_BITS-1:0]       seen, seen_next;
  bpfa_pkg::status_t                    status, status_next;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] page, page_next;
  logic                                 is_free, is_free_next;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] search_start;

  // Output register.
  logic                                 res_valid;
  bpfa_pkg::status_t                    res_status;
  logic [bpfa_pkg::PAGE_INDEX_BITS-1:0] res_page;
  logic                                 res_free;

  // Map memory with one valid bit per word.
  logic [bpfa_pkg::WORD_BITS-1:0]  map_mem [bpfa_pkg::MAP_WORDS];
  logic [bpfa_pkg::MAP_WORDS-1:0]  word_valid;
  logic [bpfa_pkg::WORD_BITS-1:0]  rd_data;
  logic                            rd_ok;
  logic                            rd_en;
  logic                            mem_we;
  logic [bpfa_pkg::WORD_BITS-1:0]  mem_wdata;

  // Word datapath.
  logic [bpfa_pkg::WADDR_BITS-1:0] waddr;
  logic [bpfa_pkg::OFF_BITS-1:0]   off;
  logic [bpfa_pkg::CHUNK_BITS-1:0] avail;
  logic [bpfa_pkg::WORD_BITS-1:0]  word;
  logic [bpfa_pkg::CHUNK_BITS-1:0] chunk;
  logic [bpfa_pkg::WORD_BITS-1:0]  mask;
  logic [bpfa_pkg::WORD_BITS-1:0]  conflict;
  logic [bpfa_pkg::WORD_BITS-1:0]  lowbit;
  logic [bpfa_pkg::WORD_BITS-1:0]  pre_taken;
  logic [bpfa_pkg::WORD_BITS-1:0]  shifted;
  logic                            seg_free;
  logic [bpfa_pkg::CHUNK_BITS-1:0] tz;
  logic [bpfa_pkg::CHUNK_BITS-1:0] seg;
  logic                            run_hit;
  logic [bpfa_pkg::SEEN_BITS-1:0]  seen_sum;
  logic                            exec_done;
  logic                            exec_reread;

  // Request decode for the requests that finish without touching the map.
  logic                            count_over;
  logic                            count_zero;
  logic                            imm_resp;
  bpfa_pkg::status_t               imm_status;
  logic                            res_load;

  assign req.ready = (state == bpfa_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign resp.valid     = res_valid;
  assign resp.status    = res_status;
  assign resp.page_no   = res_page;
  assign resp.page_free = res_free;

  assign res_load = (state == bpfa_pkg::S_RESP) && (!res_valid || resp.ready);

  // Immediate outcome of a request.
  always_comb begin
    count_over = req.count > bpfa_pkg::COUNT_BITS'(bpfa_pkg::TOTAL_FRAMES);
    count_zero = (req.count == '0);
    imm_resp   = 1'b0;
    imm_status = bpfa_pkg::STATUS_OK;
    case (bpfa_pkg::op_t'(req.operation))
      bpfa_pkg::OP_OCCUPY, bpfa_pkg::OP_FREE: begin
        imm_resp   = count_over || count_zero;
        imm_status = count_over ? bpfa_pkg::STATUS_BOUND : bpfa_pkg::STATUS_OK;
      end
      bpfa_pkg::OP_FIND: begin
        imm_resp   = count_over || count_zero;
        imm_status = bpfa_pkg::STATUS_NOMEM;
      end
      default: begin
        imm_resp   = 1'b0;
        imm_status = bpfa_pkg::STATUS_OK;
      end
    endcase
  end

  // Shared word unit: masks for run updates, stretch length for the search.
  always_comb begin
    off       = cur[bpfa_pkg::OFF_BITS-1:0];
    waddr     = cur[bpfa_pkg::PAGE_INDEX_BITS-1:bpfa_pkg::OFF_BITS];
    avail     = bpfa_pkg::CHUNK_BITS'(bpfa_pkg::WORD_BITS) - {1'b0, off};
    word      = rd_ok ? rd_data : '0;
    chunk     = (cnt_left < bpfa_pkg::COUNT_BITS'(avail)) ?
                cnt_left[bpfa_pkg::CHUNK_BITS-1:0] : avail;
    mask      = bpfa_pkg::low_ones(chunk) << off;
    conflict  = word & mask;
    lowbit    = conflict & (~conflict + bpfa_pkg::WORD_BITS'(1));
    pre_taken = mask & (lowbit - bpfa_pkg::WORD_BITS'(1));
    shifted   = word >> off;
    seg_free  = ~shifted[0];
    tz        = seg_free ? bpfa_pkg::ctz(shifted) : bpfa_pkg::ctz(~shifted);
    seg       = (tz < avail) ? tz : avail;
    run_hit   = (run_len + bpfa_pkg::COUNT_BITS'(seg)) >= n_req;
    seen_sum  = seen + bpfa_pkg::SEEN_BITS'(seg);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bpfa_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = imm_resp ? bpfa_pkg::S_RESP : bpfa_pkg::S_READ;
        end
      end
      bpfa_pkg::S_READ: begin
        state_next = bpfa_pkg::S_EXEC;
      end
      bpfa_pkg::S_EXEC: begin
        if (exec_done) begin
          state_next = bpfa_pkg::S_RESP;
        end else if (exec_reread) begin
          state_next = bpfa_pkg::S_READ;
        end
      end
      bpfa_pkg::S_RESP: begin
        if (res_load) begin
          state_next = bpfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpfa_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs and register updates.
  always_comb begin
    op_next       = op;
    cur_next      = cur;
    cnt_left_next = cnt_left;
    n_req_next    = n_req;
    run_len_next  = run_len;
    seen_next     = seen;
    status_next   = status;
    page_next     = page;
    is_free_next  = is_free;
    rd_en         = (state == bpfa_pkg::S_READ);
    mem_we        = 1'b0;
    mem_wdata     = word;
    exec_done     = 1'b0;
    exec_reread   = 1'b0;
    case (state)
      bpfa_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next       = bpfa_pkg::op_t'(req.operation);
          cnt_left_next = req.count;
          n_req_next    = req.count;
          run_len_next  = '0;
          seen_next     = '0;
          status_next   = imm_status;
          page_next     = '0;
          is_free_next  = 1'b0;
          cur_next      = (bpfa_pkg::op_t'(req.operation) == bpfa_pkg::OP_FIND) ?
                          search_start : req.start_page;
        end
      end
      bpfa_pkg::S_EXEC: begin
        case (op)
          bpfa_pkg::OP_OCCUPY: begin
            mem_we = 1'b1;
            if (conflict != '0) begin
              // Mark the frames up to the first taken one, then stop.
              mem_wdata   = word | pre_taken;
              status_next = bpfa_pkg::STATUS_TAKEN;
              exec_done   = 1'b1;
            end else begin
              mem_wdata     = word | mask;
              cnt_left_next = cnt_left - bpfa_pkg::COUNT_BITS'(chunk);
              cur_next      = cur + bpfa_pkg::PAGE_INDEX_BITS'(chunk);
              exec_done     = (cnt_left == bpfa_pkg::COUNT_BITS'(chunk));
              exec_reread   = !exec_done;
            end
          end
          bpfa_pkg::OP_FREE: begin
            mem_we        = 1'b1;
            mem_wdata     = word & ~mask;
            cnt_left_next = cnt_left - bpfa_pkg::COUNT_BITS'(chunk);
            cur_next      = cur + bpfa_pkg::PAGE_INDEX_BITS'(chunk);
            exec_done     = (cnt_left == bpfa_pkg::COUNT_BITS'(chunk));
            exec_reread   = !exec_done;
          end
          bpfa_pkg::OP_FIND: begin
            if (seg_free) begin
              if (run_hit) begin
                // The run started run_len frames before this stretch.
                page_next   = cur - run_len[bpfa_pkg::PAGE_INDEX_BITS-1:0];
                status_next = bpfa_pkg::STATUS_OK;
                exec_done   = 1'b1;
              end else begin
                run_len_next = run_len + bpfa_pkg::COUNT_BITS'(seg);
                seen_next    = seen_sum;
                cur_next     = cur + bpfa_pkg::PAGE_INDEX_BITS'(seg);
                exec_reread  = (seg == avail);
              end
            end else begin
              // An occupied stretch ends any run; give up once past a full lap.
              run_len_next = '0;
              seen_next    = seen_sum;
              if (seen_sum > bpfa_pkg::SEEN_BITS'(bpfa_pkg::TOTAL_FRAMES)) begin
                status_next = bpfa_pkg::STATUS_NOMEM;
                exec_done   = 1'b1;
              end else begin
                cur_next    = cur + bpfa_pkg::PAGE_INDEX_BITS'(seg);
                exec_reread = (seg == avail);
              end
            end
          end
          default: begin
            is_free_next = ~word[off];
            exec_done    = 1'b1;
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bpfa_pkg::S_IDLE;
      res_valid    <= 1'b0;
      search_start <= '0;
      word_valid   <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (resp.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        search_start <= cfg.search_start;
      end
      if (mem_we) begin
        word_valid[waddr] <= 1'b1;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    op       <= op_next;
    cur      <= cur_next;
    cnt_left <= cnt_left_next;
    n_req    <= n_req_next;
    run_len  <= run_len_next;
    seen     <= seen_next;
    status   <= status_next;
    page     <= page_next;
    is_free  <= is_free_next;
    if (res_load) begin
      res_status <= status;
      res_page   <= page;
      res_free   <= is_free;
    end
  end

  // Map memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= map_mem[waddr];
      rd_ok   <= word_valid[waddr];
    end
  end

`ifndef ASSERT_OFF
  // An accepted request always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != bpfa_pkg::S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // Only occupy and free write the map, and only in the execute step.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == bpfa_pkg::S_EXEC) &&
                ((op == bpfa_pkg::OP_OCCUPY) || (op == bpfa_pkg::OP_FREE))))
    else $error("map written outside an occupy or free step");

  // A run being searched is always shorter than the requested length.
  assert property (@(posedge clk) disable iff (rst)
    ((state == bpfa_pkg::S_EXEC) && (op == bpfa_pkg::OP_FIND)) |-> (run_len < n_req))
    else $error("search run length reached the request without a hit");

  // A failed request carries no page number and no free flag.
  assert property (@(posedge clk) disable iff (rst)
    (resp.valid && (resp.status != bpfa_pkg::STATUS_OK)) |->
      ((resp.page_no == '0) && !resp.page_free))
    else $error("failed result carries a page number or free flag");
`endif

endmodule
